@@ rtl/abs_pkg.sv @@
// shared types and constants for the alpha blend sprite blitter
package abs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int ADDRESS_W   = 12;
    localparam int PIXEL_W     = 32;
    localparam int CMD_DEPTH   = 4;
    localparam int RES_DEPTH   = 4;

    typedef enum logic [1:0] {
        F_BLIT    = 2'd0,
        F_WRITE   = 2'd1,
        F_READ    = 2'd2,
        F_RESTART = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_BLEND = 2'd1,
        K_WRITE = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_COL    = 3'd0,
        CFG_ORIGIN_ROW    = 3'd1,
        CFG_SPRITE_WIDTH  = 3'd2,
        CFG_SPRITE_HEIGHT = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_FRAME_HEIGHT  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        t_kind                kind;
        logic [PIXEL_W-1:0]   pixel;
        logic [ADDRESS_W-1:0] widx;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic [PIXEL_W-1:0]   read_data;
        logic                 landed;
        logic [ADDRESS_W-1:0] written_index;
        logic                 sprite_last;
    } t_result;

endpackage

@@ rtl/abs_front.sv @@
// front end: configuration, sprite counters, clipping and frame index classification
module abs_front #(
    parameter int FRAME_WORDS   = 4096,
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [abs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [abs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [1:0]                          i_func,
    input  logic [abs_pkg::PIXEL_W-1:0]         i_pixel,
    input  logic [abs_pkg::ADDRESS_W-1:0]       i_frame_address,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output abs_pkg::t_cmd                       o_cmd,
    output logic [$clog2(FRAME_WORDS)-1:0]      o_cmd_addr
);

    localparam int AW   = $clog2(FRAME_WORDS);
    localparam int CNTW = $clog2(MAX_DIMENSION);
    localparam int DW   = $clog2(MAX_DIMENSION + 1);
    localparam int PW   = ((CNTW > 10) ? CNTW : 10) + 2;
    localparam int UW   = PW - 1;
    localparam int IW   = UW + DW + 1;

    function automatic logic [DW-1:0] clamp_dim(input logic [10:0] v, input logic at_least_one);
        logic [DW-1:0] res;
        if (at_least_one && (v == '0)) begin
            res = DW'(1);
        end else if (32'(v) > 32'(MAX_DIMENSION)) begin
            res = DW'(MAX_DIMENSION);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    logic signed [10:0] r_origin_col, r_origin_row;
    logic [10:0]        r_sprite_w, r_sprite_h, r_frame_w, r_frame_h;
    logic [CNTW-1:0]    r_col, r_row, n_col, n_row;

    logic [DW-1:0]      sw, sh, fw, fh;
    logic signed [PW-1:0] pos_col, pos_row;
    logic               in_frame, is_last, accept, f1_ready, f2_ready;
    logic [CNTW:0]      col_inc, row_inc;

    logic               r_f1_v;
    abs_pkg::t_func     r_f1_func;
    logic [abs_pkg::PIXEL_W-1:0]   r_f1_pixel;
    logic [abs_pkg::ADDRESS_W-1:0] r_f1_addr;
    logic [UW-1:0]      r_f1_col, r_f1_row;
    logic               r_f1_in, r_f1_last;

    logic [IW-1:0]      idx;
    logic               idx_ok, addr_ok;
    abs_pkg::t_cmd      n_f2_cmd;
    logic [AW-1:0]      n_f2_addr;

    logic               r_f2_v;
    abs_pkg::t_cmd      r_f2_cmd;
    logic [AW-1:0]      r_f2_addr;

    assign sw = clamp_dim(r_sprite_w, 1'b1);
    assign sh = clamp_dim(r_sprite_h, 1'b1);
    assign fw = clamp_dim(r_frame_w, 1'b0);
    assign fh = clamp_dim(r_frame_h, 1'b0);

    assign f2_ready = !r_f2_v || i_cmd_ready;
    assign f1_ready = !r_f1_v || f2_ready;
    assign o_full   = !f1_ready;
    assign accept   = i_push && f1_ready;

    always_comb begin
        pos_col = $signed({{(PW-11){r_origin_col[10]}}, r_origin_col})
                + $signed({{(PW-CNTW){1'b0}}, r_col});
        pos_row = $signed({{(PW-11){r_origin_row[10]}}, r_origin_row})
                + $signed({{(PW-CNTW){1'b0}}, r_row});
        in_frame = !pos_col[PW-1] && (32'(pos_col[UW-1:0]) < 32'(fw))
                && !pos_row[PW-1] && (32'(pos_row[UW-1:0]) < 32'(fh));
        is_last  = (32'(r_col) == (32'(sw) - 32'd1)) && (32'(r_row) == (32'(sh) - 32'd1));

        col_inc = {1'b0, r_col} + 1'b1;
        row_inc = {1'b0, r_row} + 1'b1;
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            if (abs_pkg::t_func'(i_func) == abs_pkg::F_BLIT) begin
                if (32'(col_inc) >= 32'(sw)) begin
                    n_col = '0;
                    n_row = (32'(row_inc) >= 32'(sh)) ? '0 : row_inc[CNTW-1:0];
                end else begin
                    n_col = col_inc[CNTW-1:0];
                end
            end else if (abs_pkg::t_func'(i_func) == abs_pkg::F_RESTART) begin
                n_col = '0;
                n_row = '0;
            end
        end
    end

    // config and sprite position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_sprite_w   <= 11'd1;
            r_sprite_h   <= 11'd1;
            r_frame_w    <= 11'd64;
            r_frame_h    <= 11'd64;
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (abs_pkg::t_cfg_index'(i_cfg_index))
                    abs_pkg::CFG_ORIGIN_COL:    r_origin_col <= $signed(i_cfg_data);
                    abs_pkg::CFG_ORIGIN_ROW:    r_origin_row <= $signed(i_cfg_data);
                    abs_pkg::CFG_SPRITE_WIDTH:  r_sprite_w   <= i_cfg_data;
                    abs_pkg::CFG_SPRITE_HEIGHT: r_sprite_h   <= i_cfg_data;
                    abs_pkg::CFG_FRAME_WIDTH:   r_frame_w    <= i_cfg_data;
                    abs_pkg::CFG_FRAME_HEIGHT:  r_frame_h    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // stage one: clip test on the placed position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (f1_ready) begin
            r_f1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_func  <= abs_pkg::t_func'(i_func);
            r_f1_pixel <= i_pixel;
            r_f1_addr  <= i_frame_address;
            r_f1_col   <= pos_col[UW-1:0];
            r_f1_row   <= pos_row[UW-1:0];
            r_f1_in    <= in_frame;
            r_f1_last  <= is_last;
        end
    end

    // stage two: row times frame width plus column, then classify
    always_comb begin
        idx     = IW'(r_f1_row) * IW'(fw) + IW'(r_f1_col);
        idx_ok  = 32'(idx) < 32'(FRAME_WORDS);
        addr_ok = 32'(r_f1_addr) < 32'(FRAME_WORDS);

        n_f2_cmd.kind  = abs_pkg::K_NONE;
        n_f2_cmd.pixel = r_f1_pixel;
        n_f2_cmd.widx  = '0;
        n_f2_cmd.last  = 1'b0;
        n_f2_addr      = AW'(r_f1_addr);
        unique case (r_f1_func)
            abs_pkg::F_BLIT: begin
                n_f2_cmd.last = r_f1_last;
                if (r_f1_in && idx_ok) begin
                    n_f2_cmd.kind = abs_pkg::K_BLEND;
                    n_f2_cmd.widx = abs_pkg::ADDRESS_W'(idx);
                    n_f2_addr     = AW'(idx);
                end
            end
            abs_pkg::F_WRITE: begin
                if (addr_ok) n_f2_cmd.kind = abs_pkg::K_WRITE;
            end
            abs_pkg::F_READ: begin
                if (addr_ok) n_f2_cmd.kind = abs_pkg::K_READ;
            end
            abs_pkg::F_RESTART: begin
                n_f2_cmd.kind = abs_pkg::K_NONE;
            end
            default: begin
                n_f2_cmd.kind = abs_pkg::K_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (f2_ready) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_ready && r_f1_v) begin
            r_f2_cmd  <= n_f2_cmd;
            r_f2_addr <= n_f2_addr;
        end
    end

    assign o_cmd_valid = r_f2_v;
    assign o_cmd       = r_f2_cmd;
    assign o_cmd_addr  = r_f2_addr;

endmodule

@@ rtl/abs_cmd_queue.sv @@
// short command queue between the front end and the blend back end
module abs_cmd_queue #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  abs_pkg::t_cmd i_cmd,
    input  logic [AW-1:0] i_addr,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output abs_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_addr
);

    localparam int PTRW = $clog2(abs_pkg::CMD_DEPTH);

    abs_pkg::t_cmd  r_cmd_mem  [abs_pkg::CMD_DEPTH];
    logic [AW-1:0]  r_addr_mem [abs_pkg::CMD_DEPTH];
    logic [PTRW-1:0] r_wptr, r_rptr;
    logic [PTRW:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (32'(r_count) == abs_pkg::CMD_DEPTH);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cmd_mem[r_wptr]  <= i_cmd;
            r_addr_mem[r_wptr] <= i_addr;
        end
    end

    assign o_cmd  = r_cmd_mem[r_rptr];
    assign o_addr = r_addr_mem[r_rptr];

endmodule

@@ rtl/abs_back.sv @@
// back end: frame memory read-modify-write with forwarding, blend and result queue
module abs_back #(
    parameter int FRAME_WORDS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    output logic                             o_cmd_pop,
    input  abs_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(FRAME_WORDS)-1:0]   i_addr,
    output logic                             o_empty,
    input  logic                             i_pop,
    output abs_pkg::t_result                 o_result
);

    localparam int AW   = $clog2(FRAME_WORDS);
    localparam int RPW  = $clog2(abs_pkg::RES_DEPTH);
    localparam logic [7:0] ALPHA_FULL = 8'hff;

    // exact x / 255 for products of two bytes
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
        logic [8:0] sum;
        sum = 9'(div255(16'(s) * 16'(a))) + 9'(div255(16'(d) * 16'(ALPHA_FULL - a)));
        return sum[7:0];
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] src, input logic [31:0] dst);
        logic [7:0] a;
        a = src[31:24];
        return {8'h00, mix(src[23:16], dst[23:16], a), mix(src[15:8], dst[15:8], a),
                mix(src[7:0], dst[7:0], a)};
    endfunction

    logic [31:0]    mem [FRAME_WORDS];
    logic [31:0]    r_rdata;

    logic           r_b1_v;
    abs_pkg::t_cmd  r_b1_cmd;
    logic [AW-1:0]  r_b1_addr;

    logic           r_fw_v;
    logic [AW-1:0]  r_fw_addr;
    logic [31:0]    r_fw_data;

    logic [31:0]    dst, wdata;
    logic           b1_we;
    abs_pkg::t_result b1_res;

    abs_pkg::t_result r_res_mem [abs_pkg::RES_DEPTH];
    logic [RPW-1:0] r_res_wptr, r_res_rptr;
    logic [RPW:0]   r_res_count;
    logic           res_pop;

    // only take a command when the result queue can hold everything in flight
    assign o_cmd_pop = i_cmd_valid
                    && ((32'(r_res_count) + 32'(r_b1_v)) < abs_pkg::RES_DEPTH);

    // the previous cycle's write is not yet visible in the registered read
    assign dst = (r_fw_v && (r_fw_addr == r_b1_addr)) ? r_fw_data : r_rdata;

    always_comb begin
        b1_we  = 1'b0;
        wdata  = r_b1_cmd.pixel;
        b1_res.read_data     = '0;
        b1_res.landed        = 1'b0;
        b1_res.written_index = r_b1_cmd.widx;
        b1_res.sprite_last   = r_b1_cmd.last;
        unique case (r_b1_cmd.kind)
            abs_pkg::K_BLEND: begin
                b1_we         = r_b1_v;
                wdata         = blend(r_b1_cmd.pixel, dst);
                b1_res.landed = 1'b1;
            end
            abs_pkg::K_WRITE: begin
                b1_we = r_b1_v;
            end
            abs_pkg::K_READ: begin
                b1_res.read_data = dst;
            end
            abs_pkg::K_NONE: begin
                b1_we = 1'b0;
            end
            default: begin
                b1_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_rdata <= mem[i_addr];
        if (b1_we)     mem[r_b1_addr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_fw_v <= 1'b0;
        end else begin
            r_b1_v <= o_cmd_pop;
            r_fw_v <= b1_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b1_cmd  <= i_cmd;
            r_b1_addr <= i_addr;
        end
        if (b1_we) begin
            r_fw_addr <= r_b1_addr;
            r_fw_data <= wdata;
        end
    end

    // result queue, parts the blend pipe from the consumer
    assign o_empty = (r_res_count == '0);
    assign res_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wptr  <= '0;
            r_res_rptr  <= '0;
            r_res_count <= '0;
        end else begin
            if (r_b1_v)  r_res_wptr <= r_res_wptr + 1'b1;
            if (res_pop) r_res_rptr <= r_res_rptr + 1'b1;
            case ({r_b1_v, res_pop})
                2'b10:   r_res_count <= r_res_count + 1'b1;
                2'b01:   r_res_count <= r_res_count - 1'b1;
                default: r_res_count <= r_res_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b1_v) r_res_mem[r_res_wptr] <= b1_res;
    end

    assign o_result = r_res_mem[r_res_rptr];

endmodule

@@ rtl/alpha_blend_sprite_blit.sv @@
// top level of the argb8888 source-over sprite blitter with internal frame memory
// path: front stages one and two, command queue, back end read stage, then the result queue
// throughput: one item per cycle while full is low; the frame memory read-modify-write
// forwards the previous cycle's write so back-to-back pixels on one word blend correctly
// reset: synchronous active low; clears config to defaults, sprite counters and all queues
// frame memory contents are not cleared by reset
module alpha_blend_sprite_blit #(
    parameter int FRAME_WORDS   = 4096,
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [abs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [abs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_func,
    input  logic [abs_pkg::PIXEL_W-1:0]       i_pixel,
    input  logic [abs_pkg::ADDRESS_W-1:0]     i_frame_address,
    output logic                              empty,
    input  logic                              pop,
    output logic [abs_pkg::PIXEL_W-1:0]       o_read_data,
    output logic                              o_landed,
    output logic [abs_pkg::ADDRESS_W-1:0]     o_written_index,
    output logic                              o_sprite_last
);

    localparam int AW = $clog2(FRAME_WORDS);

    logic             front_valid, q_full, q_empty, q_pop;
    abs_pkg::t_cmd    front_cmd, q_cmd;
    logic [AW-1:0]    front_addr, q_addr;
    abs_pkg::t_result result;

    abs_front #(
        .FRAME_WORDS  (FRAME_WORDS),
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_pixel        (i_pixel),
        .i_frame_address(i_frame_address),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (!q_full),
        .o_cmd          (front_cmd),
        .o_cmd_addr     (front_addr)
    );

    abs_cmd_queue #(
        .AW(AW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_valid),
        .i_cmd  (front_cmd),
        .i_addr (front_addr),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_cmd  (q_cmd),
        .o_addr (q_addr)
    );

    abs_back #(
        .FRAME_WORDS(FRAME_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!q_empty),
        .o_cmd_pop  (q_pop),
        .i_cmd      (q_cmd),
        .i_addr     (q_addr),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (result)
    );

    assign o_read_data     = result.read_data;
    assign o_landed        = result.landed;
    assign o_written_index = result.written_index;
    assign o_sprite_last   = result.sprite_last;

    a_landed_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_landed) |-> (o_read_data == '0))
        else $error("landed blit result carries read data");

    a_dropped_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_landed) |-> (o_written_index == '0))
        else $error("result without a landed pixel carries a frame index");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("block not idle after reset");

endmodule

@@ tb/alpha_blend_sprite_blit_tb.sv @@
// self-checking testbench for the sprite blitter: directed table, then random phases
`timescale 1ns / 1ps

module alpha_blend_sprite_blit_tb;
    import abs_pkg::*;

    localparam int FRAME_WORDS = 4096;
    localparam int MAX_DIM     = 1024;
    localparam int ITEM_TARGET = 1650;
    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        t_func                func;
        logic [PIXEL_W-1:0]   pixel;
        logic [ADDRESS_W-1:0] addr;
    } frame_op_t;

    typedef struct packed {
        logic                  is_cfg;
        t_cfg_index            reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        frame_op_t             op;
        logic                  typed;
        t_result               want;
    } table_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   push;
    logic                   full;
    logic [1:0]             i_func;
    logic [PIXEL_W-1:0]     i_pixel;
    logic [ADDRESS_W-1:0]   i_frame_address;
    logic                   empty;
    logic                   pop;
    logic [PIXEL_W-1:0]     o_read_data;
    logic                   o_landed;
    logic [ADDRESS_W-1:0]   o_written_index;
    logic                   o_sprite_last;

    // shadow of the block: frame words, sprite counters, registers
    logic [PIXEL_W-1:0]    frame_mem [0:FRAME_WORDS-1];
    bit                    word_set [0:FRAME_WORDS-1];
    int                    filled_words [$];
    int                    sp_col;
    int                    sp_row;
    logic [CFG_DATA_W-1:0] cfg_regs [0:5];

    t_result    outcomes_due [$];
    table_row_t stim_table [$];
    int         mismatches;
    int         items_sent;
    int         cycle_count;
    int         hold_requests;
    int         hold_served;
    bit         sender_burst;
    bit         receiver_calm;

    alpha_blend_sprite_blit #(
        .FRAME_WORDS   (FRAME_WORDS),
        .MAX_DIMENSION (MAX_DIM)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_pixel         (i_pixel),
        .i_frame_address (i_frame_address),
        .empty           (empty),
        .pop             (pop),
        .o_read_data     (o_read_data),
        .o_landed        (o_landed),
        .o_written_index (o_written_index),
        .o_sprite_last   (o_sprite_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int sprite_dim(logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic int frame_dim(logic [CFG_DATA_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // frame index the next blit lands on, -1 when it is clipped
    function automatic int target_index();
        int fw, fh, col, row;
        fw  = frame_dim(cfg_regs[CFG_FRAME_WIDTH]);
        fh  = frame_dim(cfg_regs[CFG_FRAME_HEIGHT]);
        col = int'($signed(cfg_regs[CFG_ORIGIN_COL])) + sp_col;
        row = int'($signed(cfg_regs[CFG_ORIGIN_ROW])) + sp_row;
        if (col >= 0 && col < fw && row >= 0 && row < fh && row * fw + col < FRAME_WORDS)
            return row * fw + col;
        return -1;
    endfunction

    function automatic logic [PIXEL_W-1:0] blend_argb(logic [PIXEL_W-1:0] src,
                                                      logic [PIXEL_W-1:0] dst);
        int a, ch;
        logic [PIXEL_W-1:0] mixed;
        a = src[31:24];
        mixed = '0;
        for (int c = 0; c < 3; c++) begin
            ch = (int'(src[8*c +: 8]) * a) / 255 + (int'(dst[8*c +: 8]) * (255 - a)) / 255;
            mixed[8*c +: 8] = ch[7:0];
        end
        return mixed;
    endfunction

    // advances the shadow state by one op and returns the outcome it gives
    function automatic t_result apply_frame_op(frame_op_t op);
        t_result r;
        int idx, sw, sh;
        r = '0;
        case (op.func)
            F_BLIT: begin
                idx = target_index();
                if (idx >= 0) begin
                    frame_mem[idx]  = blend_argb(op.pixel, frame_mem[idx]);
                    r.landed        = 1'b1;
                    r.written_index = idx[ADDRESS_W-1:0];
                end
                sw = sprite_dim(cfg_regs[CFG_SPRITE_WIDTH]);
                sh = sprite_dim(cfg_regs[CFG_SPRITE_HEIGHT]);
                r.sprite_last = (sp_col == sw - 1 && sp_row == sh - 1);
                sp_col++;
                if (sp_col >= sw) begin
                    sp_col = 0;
                    sp_row++;
                    if (sp_row >= sh) sp_row = 0;
                end
            end
            F_WRITE: begin
                frame_mem[op.addr] = op.pixel;
                if (!word_set[op.addr]) begin
                    word_set[op.addr] = 1'b1;
                    filled_words.push_back(int'(op.addr));
                end
            end
            F_READ: begin
                r.read_data = frame_mem[op.addr];
            end
            F_RESTART: begin
                sp_col = 0;
                sp_row = 0;
            end
        endcase
        return r;
    endfunction

    function automatic void add_cfg(t_cfg_index idx, int val);
        table_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val[CFG_DATA_W-1:0];
        stim_table.push_back(row);
    endfunction

    function automatic void add_op(t_func f, logic [PIXEL_W-1:0] px, logic [ADDRESS_W-1:0] ad);
        table_row_t row;
        row = '0;
        row.op.func  = f;
        row.op.pixel = px;
        row.op.addr  = ad;
        stim_table.push_back(row);
    endfunction

    function automatic void add_typed(t_func f, logic [PIXEL_W-1:0] px,
                                      logic [ADDRESS_W-1:0] ad, logic [PIXEL_W-1:0] rd,
                                      logic ld, logic [ADDRESS_W-1:0] wi, logic sl);
        table_row_t row;
        row = '0;
        row.op.func            = f;
        row.op.pixel           = px;
        row.op.addr            = ad;
        row.typed              = 1'b1;
        row.want.read_data     = rd;
        row.want.landed        = ld;
        row.want.written_index = wi;
        row.want.sprite_last   = sl;
        stim_table.push_back(row);
    endfunction

    function automatic int pick_extreme(bit is_origin);
        case ($urandom_range(0, 3))
            0: return is_origin ? -1024 : 0;
            1: return is_origin ? 1023 : 1;
            2: return is_origin ? 0 : MAX_DIM;
            default: return is_origin ? -1 : 2047;
        endcase
    endfunction

    task automatic flag_mismatch(string field, logic [PIXEL_W-1:0] got,
                                 logic [PIXEL_W-1:0] want);
        $display("mismatch on %s at cycle %0d: got %h, want %h", field, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic send_item(frame_op_t op, bit typed, t_result want);
        int gap;
        t_result outcome;
        gap = sender_burst ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push            <= 1'b1;
        i_func          <= op.func;
        i_pixel         <= op.pixel;
        i_frame_address <= op.addr;
        do @(posedge i_clk); while (full);
        items_sent++;
        outcome = apply_frame_op(op);
        outcomes_due.push_back(typed ? want : outcome);
    endtask

    // a blit onto a word never written would blend with garbage, so fill it first
    task automatic issue(frame_op_t op, bit typed, t_result want);
        int ti;
        frame_op_t fill;
        if (op.func == F_BLIT) begin
            ti = target_index();
            if (ti >= 0 && !word_set[ti]) begin
                fill.func  = F_WRITE;
                fill.pixel = $urandom;
                fill.addr  = ti[ADDRESS_W-1:0];
                send_item(fill, 1'b0, '0);
            end
        end
        send_item(op, typed, want);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_regs[idx] = val;
    endtask

    task automatic close_config();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result side: compare each transfer, then draw the next stall
    initial begin : result_side
        int stall_left;
        bit took;
        t_result want;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            took = 1'b0;
            if (i_rst_n && pop && !empty) begin
                took = 1'b1;
                if (outcomes_due.size() == 0) begin
                    flag_mismatch("unexpected result", o_read_data, '0);
                end else begin
                    want = outcomes_due.pop_front();
                    if (o_read_data !== want.read_data)
                        flag_mismatch("read_data", o_read_data, want.read_data);
                    if (o_landed !== want.landed)
                        flag_mismatch("landed", o_landed, want.landed);
                    if (o_written_index !== want.written_index)
                        flag_mismatch("written_index", o_written_index, want.written_index);
                    if (o_sprite_last !== want.sprite_last)
                        flag_mismatch("sprite_last", o_sprite_last, want.sprite_last);
                end
            end
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end else if (took) begin
                stall_left = receiver_calm ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout: %0d results still due", outcomes_due.size());
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        bit cfg_open;
        bit extreme;
        int phase, n_items, r, fw, fh, idx, k;
        int ocol, orow, swv, shv, fwv, fhv;
        frame_op_t op;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        push            = 1'b0;
        i_func          = F_RESTART;
        i_pixel         = '0;
        i_frame_address = '0;
        mismatches      = 0;
        items_sent      = 0;
        hold_requests   = 0;
        hold_served     = 0;
        sender_burst    = 1'b0;
        receiver_calm   = 1'b0;
        sp_col          = 0;
        sp_row          = 0;
        cfg_regs[CFG_ORIGIN_COL]    = 0;
        cfg_regs[CFG_ORIGIN_ROW]    = 0;
        cfg_regs[CFG_SPRITE_WIDTH]  = 1;
        cfg_regs[CFG_SPRITE_HEIGHT] = 1;
        cfg_regs[CFG_FRAME_WIDTH]   = 64;
        cfg_regs[CFG_FRAME_HEIGHT]  = 64;

        // reset defaults: 1x1 sprite at the origin of a 64x64 frame
        add_typed(F_RESTART, 32'h0, 12'h000, 32'h0, 1'b0, 12'h000, 1'b0);
        add_typed(F_WRITE, 32'h00ABCDEF, 12'h000, 32'h0, 1'b0, 12'h000, 1'b0);
        add_typed(F_READ, 32'h0, 12'h000, 32'h00ABCDEF, 1'b0, 12'h000, 1'b0);
        // opaque source replaces the colour, alpha byte comes back zero
        add_typed(F_BLIT, 32'hFF123456, 12'h000, 32'h0, 1'b1, 12'h000, 1'b1);
        add_typed(F_READ, 32'h0, 12'h000, 32'h00123456, 1'b0, 12'h000, 1'b0);
        // transparent source leaves the frame word alone
        add_typed(F_BLIT, 32'h00FFFFFF, 12'h000, 32'h0, 1'b1, 12'h000, 1'b1);
        add_typed(F_READ, 32'h0, 12'h000, 32'h00123456, 1'b0, 12'h000, 1'b0);
        add_typed(F_WRITE, 32'hFFFFFFFF, 12'hFFF, 32'h0, 1'b0, 12'h000, 1'b0);
        add_typed(F_READ, 32'h0, 12'hFFF, 32'hFFFFFFFF, 1'b0, 12'h000, 1'b0);
        add_typed(F_WRITE, 32'hA5A5A5A5, 12'hAAA, 32'h0, 1'b0, 12'h000, 1'b0);
        add_typed(F_READ, 32'h0, 12'hAAA, 32'hA5A5A5A5, 1'b0, 12'h000, 1'b0);
        add_typed(F_WRITE, 32'h5A5A5A5A, 12'h555, 32'h0, 1'b0, 12'h000, 1'b0);
        add_typed(F_READ, 32'h0, 12'h555, 32'h5A5A5A5A, 1'b0, 12'h000, 1'b0);
        add_op(F_BLIT, 32'h80FF00FF, 12'h000);
        add_op(F_READ, 32'h0, 12'h000);
        // zero sprite size behaves as one pixel
        add_cfg(CFG_ORIGIN_COL, 2);
        add_cfg(CFG_ORIGIN_ROW, 3);
        add_cfg(CFG_SPRITE_WIDTH, 0);
        add_cfg(CFG_SPRITE_HEIGHT, 0);
        add_op(F_BLIT, 32'h7F808080, 12'h000);
        // zero frame width drops everything
        add_cfg(CFG_FRAME_WIDTH, 0);
        add_typed(F_BLIT, 32'hFFFFFFFF, 12'h000, 32'h0, 1'b0, 12'h000, 1'b1);
        // oversize frame saturates, position past the end of memory is dropped
        add_cfg(CFG_FRAME_WIDTH, 2047);
        add_cfg(CFG_FRAME_HEIGHT, 2047);
        add_cfg(CFG_ORIGIN_COL, 0);
        add_cfg(CFG_ORIGIN_ROW, 5);
        add_typed(F_BLIT, 32'hFFFFFFFF, 12'h000, 32'h0, 1'b0, 12'h000, 1'b1);
        // last word of memory
        add_cfg(CFG_ORIGIN_COL, 1023);
        add_cfg(CFG_ORIGIN_ROW, 3);
        add_op(F_BLIT, 32'h40000000, 12'h000);
        add_cfg(CFG_ORIGIN_COL, -1024);
        add_cfg(CFG_ORIGIN_ROW, -1024);
        add_typed(F_BLIT, 32'hFFFFFFFF, 12'h000, 32'h0, 1'b0, 12'h000, 1'b1);
        // 2x2 sprite: counter advance, wrap into the next sprite, restart
        add_cfg(CFG_ORIGIN_COL, 0);
        add_cfg(CFG_ORIGIN_ROW, 0);
        add_cfg(CFG_SPRITE_WIDTH, 2);
        add_cfg(CFG_SPRITE_HEIGHT, 2);
        add_cfg(CFG_FRAME_WIDTH, 64);
        add_cfg(CFG_FRAME_HEIGHT, 64);
        add_op(F_BLIT, 32'hC0102030, 12'h000);
        add_op(F_BLIT, 32'h01FEDCBA, 12'h000);
        add_op(F_BLIT, 32'hFE0F0F0F, 12'h000);
        add_op(F_BLIT, 32'h7FFFFFFF, 12'h000);
        add_op(F_BLIT, 32'h3355AA77, 12'h000);
        add_typed(F_RESTART, 32'h0, 12'h000, 32'h0, 1'b0, 12'h000, 1'b0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 1'b0;
        for (int i = 0; i < stim_table.size(); i++) begin
            if (stim_table[i].is_cfg) begin
                if (!cfg_open) begin
                    drain_results();
                    cfg_open = 1'b1;
                end
                write_register(stim_table[i].reg_idx, stim_table[i].reg_val);
            end else begin
                if (cfg_open) begin
                    close_config();
                    cfg_open = 1'b0;
                end
                issue(stim_table[i].op, stim_table[i].typed, stim_table[i].want);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_results();
            extreme = (phase % 7 == 3);
            if (extreme) begin
                ocol = pick_extreme(1'b1);
                orow = pick_extreme(1'b1);
                swv  = pick_extreme(1'b0);
                shv  = pick_extreme(1'b0);
                fwv  = pick_extreme(1'b0);
                fhv  = pick_extreme(1'b0);
            end else begin
                // small frames with the sprite straddling the edges
                fwv  = $urandom_range(1, 24);
                fhv  = $urandom_range(1, 24);
                swv  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
                shv  = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
                ocol = int'($urandom_range(0, fwv + 4)) - 4;
                orow = int'($urandom_range(0, fhv + 4)) - 4;
            end
            write_register(CFG_ORIGIN_COL, ocol[CFG_DATA_W-1:0]);
            write_register(CFG_ORIGIN_ROW, orow[CFG_DATA_W-1:0]);
            write_register(CFG_SPRITE_WIDTH, swv[CFG_DATA_W-1:0]);
            write_register(CFG_SPRITE_HEIGHT, shv[CFG_DATA_W-1:0]);
            write_register(CFG_FRAME_WIDTH, fwv[CFG_DATA_W-1:0]);
            write_register(CFG_FRAME_HEIGHT, fhv[CFG_DATA_W-1:0]);
            close_config();

            sender_burst  = (phase % 4 == 1);
            receiver_calm = (phase % 4 == 1);
            n_items = $urandom_range(20, 90);
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering, so the queues fill
                hold_requests++;
                sender_burst = 1'b1;
                n_items = 60;
            end

            for (k = 0; k < n_items; k++) begin
                if (phase == 5 && k == n_items / 2) drain_results();
                r        = $urandom_range(0, 99);
                op.pixel = $urandom;
                op.addr  = '0;
                if (r < 66) begin
                    op.func = F_BLIT;
                    case ($urandom_range(0, 3))
                        0: op.pixel[31:24] = 8'h00;
                        1: op.pixel[31:24] = 8'hFF;
                        default: ;
                    endcase
                end else if (r < 78) begin
                    op.func = F_WRITE;
                    fw  = frame_dim(cfg_regs[CFG_FRAME_WIDTH]);
                    fh  = frame_dim(cfg_regs[CFG_FRAME_HEIGHT]);
                    idx = $urandom_range(0, FRAME_WORDS - 1);
                    if (fw > 0 && fh > 0 && $urandom_range(0, 1) == 1) begin
                        idx = int'($urandom_range(0, fh - 1)) * fw
                            + int'($urandom_range(0, fw - 1));
                        if (idx >= FRAME_WORDS) idx = $urandom_range(0, FRAME_WORDS - 1);
                    end
                    op.addr = idx[ADDRESS_W-1:0];
                end else if (r < 93 && filled_words.size() != 0) begin
                    op.func = F_READ;
                    idx     = filled_words[$urandom_range(0, filled_words.size() - 1)];
                    op.addr = idx[ADDRESS_W-1:0];
                end else begin
                    op.func = F_RESTART;
                end
                issue(op, 1'b0, '0);
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
